// ===== hw/rtl/uuid7_pkg.sv =====
// Package for the UUIDv7 generator: field widths, item layouts, version and
// variant codes, register map.
// No dependencies.
package uuid7_pkg;

	localparam int TIME_W     = 48;
	localparam int COUNT_W    = 42;
	localparam int CNT_LOW_W  = 30;
	localparam int CNT_HIGH_W = COUNT_W - CNT_LOW_W;
	localparam int RAND_W     = 64;
	localparam int UUID_W     = 64;
	localparam int LOW_RAND_W = 32;
	localparam int WINDOW_W   = 20;
	localparam int ADDR_W     = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [3:0]          VERSION_NIBBLE = 4'h7;
	localparam logic [1:0]          VARIANT_CODE   = 2'b10;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 20'd10000;

	// register index, taken from paddr[2]
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_ROLLBACK_WINDOW = 1'b0;

	// input request, time_ms in the lowest bits
	typedef struct packed {
		logic [RAND_W-1:0] random_low;
		logic [RAND_W-1:0] random_high;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	// result request, uuid_high in the lowest bits
	typedef struct packed {
		logic [UUID_W-1:0] uuid_low;
		logic [UUID_W-1:0] uuid_high;
	} out_item_t;

	localparam int IN_DATA_W  = $bits(in_item_t);
	localparam int OUT_DATA_W = $bits(out_item_t);

endpackage

// ===== hw/rtl/uuid_v7_monotonic_generator.sv =====
// UUIDv7 generator top level: input register, timestamp/counter update,
// result register, APB register for the rollback window.
// Depends on uuid7_pkg.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+----------------------------------------
//  s_axis    | in  | tvalid/tready        | tdata: time_ms, random_high, random_low
//  m_axis    | out | tvalid/tready        | tdata: uuid_high, uuid_low
//  apb       | in  | psel/penable/pready  | rollback_window at address 0
//
// One UUID per clock sustained while m_axis_tready holds; an accepted request
// passes the input register, then the result register, before m_axis_tvalid.
// The timestamp/counter state updates on the edge the result register loads,
// so the next request in the input register already sees it.
// A stalled output holds its result; the input register still takes one more
// request, then s_axis_tready drops until the output drains.
// Reset clears the stored timestamp and counter and sets the window to 10000.
module uuid_v7_monotonic_generator
	import uuid7_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [47:0] time_ms, [111:48] random_high, [175:112] random_low
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [63:0] uuid_high, [127:64] uuid_low
	output logic [OUT_DATA_W-1:0] m_axis_tdata,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic                  valid_s1;
	in_item_t              item_s1;
	logic                  valid_s2;
	out_item_t             result_s2;

	logic [TIME_W-1:0]     stored_time_q;
	logic [COUNT_W-1:0]    count_q;
	logic [WINDOW_W-1:0]   window_q;

	logic                  out_free;
	logic                  advance;
	logic                  cfg_wr;
	reg_idx_t              reg_idx;

	logic                  same_time;
	logic                  in_window;
	logic                  count_on;
	logic                  cnt_max;
	logic [TIME_W-1:0]     time_diff;
	logic [COUNT_W-1:0]    seed;
	logic [TIME_W-1:0]     time_n;
	logic [COUNT_W-1:0]    count_n;
	out_item_t             result_n;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_ROLLBACK_WINDOW: prdata = {{(APB_DATA_W-WINDOW_W){1'b0}}, window_q};
			default:             prdata = '0;
		endcase
	end

	// count on the stored timestamp when equal, or behind it by less than the window
	always_comb begin
		same_time = stored_time_q == item_s1.time_ms;
		time_diff = stored_time_q - item_s1.time_ms;
		in_window = (stored_time_q > item_s1.time_ms) &&
			(time_diff < {{(TIME_W-WINDOW_W){1'b0}}, window_q});
		count_on  = same_time || in_window;
		cnt_max   = &count_q;
		seed      = {item_s1.random_high[CNT_HIGH_W-1:0],
			item_s1.random_low[LOW_RAND_W+CNT_LOW_W-1:LOW_RAND_W]};

		if (count_on && !cnt_max) begin
			time_n  = stored_time_q;
			count_n = count_q + COUNT_W'(1);
		end else if (count_on) begin
			// counter wrap: borrow the next millisecond and reseed
			time_n  = stored_time_q + TIME_W'(1);
			count_n = seed;
		end else begin
			time_n  = item_s1.time_ms;
			count_n = seed;
		end

		// reseeded results lay out the same as counted ones
		result_n.uuid_high = {time_n, VERSION_NIBBLE, count_n[COUNT_W-1:CNT_LOW_W]};
		result_n.uuid_low  = {VARIANT_CODE, count_n[CNT_LOW_W-1:0],
			item_s1.random_low[LOW_RAND_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			stored_time_q <= '0;
			count_q       <= '0;
			window_q      <= WINDOW_RESET;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				valid_s2 <= valid_s1;
			if (advance) begin
				stored_time_q <= time_n;
				count_q       <= count_n;
			end
			if (cfg_wr && reg_idx == REG_ROLLBACK_WINDOW)
				window_q <= pwdata[WINDOW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			item_s1 <= in_item_t'(s_axis_tdata);
		if (advance)
			result_s2 <= result_n;
	end

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && count_on && !cnt_max |=>
			count_q == $past(count_q) + COUNT_W'(1) && $stable(stored_time_q))
		else $error("counter did not step on a counted request");

	a_wrap_time: assert property (@(posedge clk) disable iff (!arst_n)
		advance && count_on && cnt_max |=>
			stored_time_q == $past(stored_time_q) + TIME_W'(1))
		else $error("stored timestamp did not advance on counter wrap");

	a_result_marks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:12] == VERSION_NIBBLE &&
			m_axis_tdata[OUT_DATA_W-1 -: 2] == VARIANT_CODE)
		else $error("result lacks version or variant bits");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled without a full, blocked pipeline");

endmodule

// ===== test/uuid_v7_monotonic_generator_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the UUIDv7 generator. It watches the stream and APB ports,
// predicts each UUID from its own timestamp/counter state and compares them.
// Depends on uuid7_pkg.
module uuid_v7_monotonic_generator_checker
	import uuid7_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// [47:0] time_ms, [111:48] random_high, [175:112] random_low
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,

	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [63:0] uuid_high, [127:64] uuid_low
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,

	output int                    fail_count,
	output int                    pending,
	output int                    checked
);

	logic [TIME_W-1:0]   last_time;
	logic [COUNT_W-1:0]  seq;
	logic [WINDOW_W-1:0] window;
	out_item_t           uuid_q[$];
	out_item_t           got;
	out_item_t           want;

	task automatic report(input string what, input logic [63:0] got_v, input logic [63:0] want_v);
		$display("ERROR %0t: %s: got %h, expected %h", $time, what, got_v, want_v);
		fail_count++;
	endtask

	// Advances the timestamp/counter state by one request and builds its UUID.
	function automatic out_item_t issue_uuid(input in_item_t req);
		logic [TIME_W:0]    reach;
		logic [COUNT_W:0]   bumped;
		logic [COUNT_W-1:0] seed;
		logic               counting;
		out_item_t          u;
		seed = {req.random_high[CNT_HIGH_W-1:0],
			req.random_low[LOW_RAND_W +: CNT_LOW_W]};
		reach = {1'b0, req.time_ms} + window;
		counting = (last_time == req.time_ms) ||
			(last_time > req.time_ms && {1'b0, last_time} < reach);
		bumped = {1'b0, seq} + 1'b1;
		if (counting && !bumped[COUNT_W]) begin
			seq = bumped[COUNT_W-1:0];
		end else begin
			// overflow bumps the stored timestamp (wraps at 48 bits), fresh takes the new one
			last_time = counting ? last_time + 1'b1 : req.time_ms;
			seq = seed;
		end
		u.uuid_high = {last_time, VERSION_NIBBLE, seq[COUNT_W-1:CNT_LOW_W]};
		u.uuid_low  = {VARIANT_CODE, seq[CNT_LOW_W-1:0], req.random_low[LOW_RAND_W-1:0]};
		return u;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			last_time = '0;
			seq = '0;
			window = WINDOW_RESET;
			uuid_q.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (psel && penable && pready && reg_idx_t'(paddr[2]) == REG_ROLLBACK_WINDOW) begin
				if (pwrite)
					window = pwdata[WINDOW_W-1:0];
				else if (prdata !== APB_DATA_W'(window))
					report("rollback_window read", 64'(prdata), 64'(window));
			end
			if (s_axis_tvalid && s_axis_tready)
				uuid_q.push_back(issue_uuid(in_item_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = out_item_t'(m_axis_tdata);
				if (uuid_q.size() == 0) begin
					report("uuid_high with no request pending", got.uuid_high, '0);
				end else begin
					want = uuid_q.pop_front();
					if (got.uuid_high !== want.uuid_high)
						report("uuid_high", got.uuid_high, want.uuid_high);
					if (got.uuid_low !== want.uuid_low)
						report("uuid_low", got.uuid_low, want.uuid_low);
					checked++;
				end
			end
		end
		pending <= uuid_q.size();
	end

endmodule

// ===== test/uuid_v7_monotonic_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the UUIDv7 generator: clock, reset, request and APB
// stimulus, random output stalls, timeout and verdict.
// Depends on uuid7_pkg, uuid_v7_monotonic_generator and its checker.
module uuid_v7_monotonic_generator_tb;
	import uuid7_pkg::*;

	// timeout limit for about 1100 requests, stalls included
	localparam int LIMIT = 200000;
	localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
	localparam int PHASE_ITEMS = 150;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int pending;
	int checked;
	int cycles = 0;
	int sent = 0;
	int settings = 0;
	bit steady = 1'b0;
	logic [TIME_W-1:0]   last_sent = '0;
	logic [WINDOW_W-1:0] window = WINDOW_RESET;

	uuid_v7_monotonic_generator dut (.*);
	uuid_v7_monotonic_generator_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending);
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= steady || ($urandom_range(99) >= 35);
	end

	task automatic send(input logic [TIME_W-1:0] t, input logic [RAND_W-1:0] rh,
		input logic [RAND_W-1:0] rl);
		in_item_t req;
		if (!steady && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req.time_ms = t;
		req.random_high = rh;
		req.random_low = rl;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		last_sent = t;
		sent++;
	endtask

	task automatic apb_access(input logic wr, input logic [WINDOW_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'({REG_ROLLBACK_WINDOW, 2'b00});
		// upper bits are don't-care for the register
		pwdata <= {12'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// waits out every UUID in flight before touching the register
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_window(input logic [WINDOW_W-1:0] w);
		drain();
		repeat (4) @(posedge clk);
		apb_access(1'b1, w);
		apb_access(1'b0, '0);
		window = w;
		settings++;
	endtask

	task automatic send_random();
		logic [TIME_W-1:0] t;
		logic [RAND_W-1:0] rh;
		logic [RAND_W-1:0] rl;
		int r;
		r = $urandom_range(99);
		rh = {$urandom, $urandom};
		rl = {$urandom, $urandom};
		if (r < 40)
			t = last_sent;
		else if (r < 58)
			t = last_sent - TIME_W'($urandom_range(int'(window) + 1, 1));
		else if (r < 68)
			// one inside, on, or one past the window edge
			t = last_sent - TIME_W'(window) + TIME_W'($urandom_range(2)) - 1'b1;
		else if (r < 80)
			t = last_sent + TIME_W'($urandom_range(1000, 1));
		else if (r < 92)
			t = TIME_W'({$urandom, $urandom});
		else
			t = $urandom_range(1) ? T_MAX : '0;
		// counter seed at or next to its maximum, so later counting overflows
		r = $urandom_range(99);
		if (r < 8) begin
			rh[CNT_HIGH_W-1:0] = '1;
			rl[LOW_RAND_W +: CNT_LOW_W] = '1;
			if (r < 3)
				rl[LOW_RAND_W] = 1'b0;
		end
		send(t, rh, rl);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, '0);

		send('0, '0, '0);
		send('0, '1, '1);
		send(T_MAX, '1, '1);
		// one behind at full counter: overflow wraps the timestamp to zero
		send(T_MAX - 1, '0, '0);
		send('0, {$urandom, $urandom}, {$urandom, $urandom});
		send(T_MAX, {$urandom, $urandom}, {$urandom, $urandom});
		send(T_MAX - 9999, {$urandom, $urandom}, {$urandom, $urandom});
		send(T_MAX - 10000, {$urandom, $urandom}, {$urandom, $urandom});
		send(T_MAX - 9997, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send(48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send(48'hAAAA_AAAA_AAAA, '1, '1);

		set_window('0);
		send(48'hAAAA_AAAA_AAAA, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'hAAAA_AAAA_AAA9, {$urandom, $urandom}, {$urandom, $urandom});

		set_window('1);
		send(48'h1234_5678_9ABC, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'h1234_5668_9ABD, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'h1234_5668_9ABD, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'h1234_5668_9ABC, {$urandom, $urandom}, {$urandom, $urandom});

		set_window(WINDOW_W'(1));
		send(48'h0000_0001_0000, 64'h0000_0000_0000_0FFF, 64'h3FFF_FFFF_0000_0000);
		send(48'h0000_0001_0000, {$urandom, $urandom}, {$urandom, $urandom});
		send(48'h0000_0000_FFFF, {$urandom, $urandom}, {$urandom, $urandom});

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_window(WINDOW_RESET);
				1: set_window('0);
				2: set_window('1);
				3: set_window(WINDOW_W'(16));
				4: set_window(WINDOW_W'($urandom));
				5: set_window(WINDOW_W'(1));
				default: set_window(WINDOW_W'($urandom_range(200, 2)));
			endcase
			steady = (p == 2);
			repeat (PHASE_ITEMS) send_random();
		end
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		$display("%0d UUID requests over %0d window settings, %0d results compared",
			sent, settings, checked);
		$display("counting, fresh seeding, counter overflow, window edges, 48-bit wrap");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
